// ----- rtl/ilha_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the implicit list heap allocator.
// Used by the top level, the tag memory and the testbench; depends on nothing.
package ilha_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] block_addr;
    logic [16:0] request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_addr;
    logic [16:0] copy_bytes;
  } rsp_t;

  localparam logic [1:0] OP_MALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NULL = 2'd1;
  localparam logic [1:0] STATUS_OOM  = 2'd2;

  localparam logic CFG_GROW_CHUNK = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  localparam int CFG_WIDTH      = 17;
  localparam int TAG_BYTES      = 8;
  localparam int MIN_BLOCK      = 16;
  localparam int LIST_START     = 8;
  localparam int RESET_CHUNK    = 4096;
  localparam int RESET_LIMIT    = 65536;
  localparam int RESET_HEAP_END = 16 + RESET_CHUNK;
  localparam int PROLOGUE_TAG   = TAG_BYTES + 1;
  localparam int EPILOGUE_TAG   = 1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_V_H,
    ST_V_F,
    ST_RA_NX,
    ST_RA_WR,
    ST_FF_RD,
    ST_FF_CHK,
    ST_GR_CALC,
    ST_GR_W1,
    ST_GR_W2,
    ST_GR_W3,
    ST_M_H,
    ST_M_PF,
    ST_M_NH,
    ST_M_DEC,
    ST_M_W1,
    ST_M_W2,
    ST_P_RD,
    ST_P_SZ,
    ST_P_W1,
    ST_P_W2,
    ST_P_W3,
    ST_P_W4,
    ST_R_RD,
    ST_R_SZ,
    ST_R_W1,
    ST_R_W2,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/implicit_list_heap_allocator.sv -----
`timescale 1ns / 1ps
// Top level of the implicit list heap allocator: request sequencer and config.
// Uses ilha_pkg and instantiates ilha_tag_mem.
//
// Keeps the boundary tags of a byte heap in one word memory and serves malloc,
// free and realloc one word at a time. Each tag access has its own state, and
// the first-fit walk reads each block it visits in turn; the walk over the heap
// sets how long a request takes, and the result may wait on rsp_stall. After
// reset the memory is filled with the initial heap layout, during which no
// request is taken. Configuration writes are taken at any time and must be made
// while idle. A realloc that moves reports the byte count that an outside copier
// must move; payload data is not stored here.
module implicit_list_heap_allocator import ilha_pkg::*; #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int IW = $clog2(HEAP_WORDS);
  localparam int AW = (IW + 4 > 18) ? IW + 4 : 18;
  localparam logic [AW:0] HEAP_BYTES = (AW+1)'(HEAP_WORDS * 4);

  state_t state, state_next;

  req_t                 cur;
  logic [CFG_WIDTH-1:0] grow_chunk;
  logic [CFG_WIDTH-1:0] heap_limit;
  logic [AW-1:0]        heap_end;
  logic [AW-1:0]        wp;
  logic [AW-1:0]        sz;
  logic [AW-1:0]        blk;
  logic [AW-1:0]        asize;
  logic [AW-1:0]        p;
  logic [AW-1:0]        ps;
  logic                 pu;
  logic [31:0]          htag;
  logic                 move;
  logic                 in_grow;
  logic                 split;
  logic [1:0]           status;
  logic [AW-1:0]        res;
  logic [AW-1:0]        copy;

  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [31:0]          mem_wd;
  logic [31:0]          mem_rd;
  logic                 mem_ready;

  logic [AW-1:0]        bp;
  logic [AW-1:0]        rd_size;
  logic                 rd_used;
  logic                 pre_bad;
  logic                 zero_size;
  logic [AW-1:0]        asize_calc;
  logic [AW-1:0]        ext;
  logic [AW-3:0]        gwords;
  logic [AW-1:0]        gsz;
  logic [AW:0]          grow_end;
  logic                 grow_fail;
  logic                 hdr_bad;
  logic [AW-1:0]        nx_sum;
  logic                 put_end;
  logic                 merge_end;
  logic                 done_ld;

  ilha_tag_mem #(
    .HEAP_WORDS (HEAP_WORDS),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wd    (mem_wd),
    .rd    (mem_rd),
    .ready (mem_ready)
  );

  assign bp         = AW'(cur.block_addr);
  assign rd_size    = {mem_rd[AW-1:3], 3'b000};
  assign rd_used    = mem_rd[0];
  assign zero_size  = cur.request_size == '0;
  assign pre_bad    = (cur.block_addr[2:0] != 3'b000) || (bp < AW'(LIST_START + TAG_BYTES));
  assign asize_calc = (cur.request_size <= CFG_WIDTH'(TAG_BYTES)) ? AW'(MIN_BLOCK) :
                      ((AW'(cur.request_size) + AW'(2 * TAG_BYTES - 1)) & ~AW'(7));
  assign ext        = (asize > AW'(grow_chunk)) ? asize : AW'(grow_chunk);
  assign gwords     = ext[AW-1:2] + (AW-2)'(ext[2]);
  assign gsz        = {gwords, 2'b00};
  assign grow_end   = {1'b0, heap_end} + {1'b0, gsz};
  assign grow_fail  = (grow_end > (AW+1)'(heap_limit)) || (grow_end > HEAP_BYTES);
  assign hdr_bad    = !rd_used || (rd_size < AW'(MIN_BLOCK)) ||
                      (({1'b0, bp} + {1'b0, rd_size}) > {1'b0, heap_end});
  assign nx_sum     = rd_size + blk;
  assign put_end    = (state == ST_P_W2 && !split) || state == ST_P_W4;
  assign merge_end  = (state == ST_M_DEC && pu && rd_used) || state == ST_M_W2;
  assign done_ld    = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
  assign req_stall  = !(state == ST_IDLE && mem_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = '0;
    mem_wd     = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && mem_ready) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        mem_addr = bp - AW'(4);
        unique case (cur.op)
          OP_MALLOC: state_next = zero_size ? ST_DONE : ST_FF_RD;
          OP_FREE: begin
            if (pre_bad) begin
              state_next = ST_DONE;
            end else begin
              mem_re     = 1'b1;
              state_next = ST_V_H;
            end
          end
          OP_REALLOC: begin
            if (cur.block_addr == '0) begin
              state_next = zero_size ? ST_DONE : ST_FF_RD;
            end else if (pre_bad) begin
              state_next = ST_DONE;
            end else begin
              mem_re     = 1'b1;
              state_next = ST_V_H;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_V_H: begin
        mem_addr = bp + rd_size - AW'(8);
        if (hdr_bad) begin
          state_next = ST_DONE;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_V_F;
        end
      end
      ST_V_F: begin
        mem_addr = bp + blk - AW'(4);
        if (mem_rd != htag) begin
          state_next = ST_DONE;
        end else if (cur.op == OP_FREE || zero_size) begin
          state_next = ST_R_RD;
        end else if (asize <= blk) begin
          state_next = ST_P_RD;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_RA_NX;
        end
      end
      ST_RA_NX: begin
        state_next = (!rd_used && nx_sum >= asize) ? ST_RA_WR : ST_FF_RD;
      end
      ST_RA_WR: begin
        mem_we     = 1'b1;
        mem_addr   = wp - AW'(4);
        mem_wd     = 32'(sz);
        state_next = ST_P_RD;
      end
      ST_FF_RD: begin
        mem_addr = p - AW'(4);
        if (p < heap_end) begin
          mem_re     = 1'b1;
          state_next = ST_FF_CHK;
        end else begin
          state_next = ST_GR_CALC;
        end
      end
      ST_FF_CHK: begin
        priority if (rd_size == '0) begin
          state_next = ST_GR_CALC;
        end else if (!rd_used && asize <= rd_size) begin
          state_next = ST_P_RD;
        end else begin
          state_next = ST_FF_RD;
        end
      end
      ST_GR_CALC: state_next = grow_fail ? ST_DONE : ST_GR_W1;
      ST_GR_W1: begin
        mem_we     = 1'b1;
        mem_addr   = wp - AW'(4);
        mem_wd     = 32'(sz);
        state_next = ST_GR_W2;
      end
      ST_GR_W2: begin
        mem_we     = 1'b1;
        mem_addr   = wp + sz - AW'(8);
        mem_wd     = 32'(sz);
        state_next = ST_GR_W3;
      end
      ST_GR_W3: begin
        mem_we     = 1'b1;
        mem_addr   = wp + sz - AW'(4);
        mem_wd     = 32'(EPILOGUE_TAG);
        state_next = ST_M_H;
      end
      ST_M_H: begin
        mem_re     = 1'b1;
        mem_addr   = wp - AW'(4);
        state_next = ST_M_PF;
      end
      ST_M_PF: begin
        mem_re     = 1'b1;
        mem_addr   = wp - AW'(8);
        state_next = ST_M_NH;
      end
      ST_M_NH: begin
        mem_re     = 1'b1;
        mem_addr   = wp + sz - AW'(4);
        state_next = ST_M_DEC;
      end
      ST_M_DEC: begin
        if (pu && rd_used) begin
          state_next = in_grow ? ST_P_RD : ST_DONE;
        end else begin
          state_next = ST_M_W1;
        end
      end
      ST_M_W1: begin
        mem_we     = 1'b1;
        mem_addr   = wp - AW'(4);
        mem_wd     = 32'(sz);
        state_next = ST_M_W2;
      end
      ST_M_W2: begin
        mem_we     = 1'b1;
        mem_addr   = wp + sz - AW'(8);
        mem_wd     = 32'(sz);
        state_next = in_grow ? ST_P_RD : ST_DONE;
      end
      ST_P_RD: begin
        mem_re     = 1'b1;
        mem_addr   = wp - AW'(4);
        state_next = ST_P_SZ;
      end
      ST_P_SZ: state_next = ST_P_W1;
      ST_P_W1: begin
        mem_we     = 1'b1;
        mem_addr   = wp - AW'(4);
        mem_wd     = split ? (32'(asize) | 32'd1) : (32'(sz) | 32'd1);
        state_next = ST_P_W2;
      end
      ST_P_W2: begin
        mem_we   = 1'b1;
        mem_addr = split ? (wp + asize - AW'(8)) : (wp + sz - AW'(8));
        mem_wd   = split ? (32'(asize) | 32'd1) : (32'(sz) | 32'd1);
        if (split) begin
          state_next = ST_P_W3;
        end else begin
          state_next = move ? ST_R_RD : ST_DONE;
        end
      end
      ST_P_W3: begin
        mem_we     = 1'b1;
        mem_addr   = wp + asize - AW'(4);
        mem_wd     = 32'(sz - asize);
        state_next = ST_P_W4;
      end
      ST_P_W4: begin
        mem_we     = 1'b1;
        mem_addr   = wp + sz - AW'(8);
        mem_wd     = 32'(sz - asize);
        state_next = move ? ST_R_RD : ST_DONE;
      end
      ST_R_RD: begin
        mem_re     = 1'b1;
        mem_addr   = wp - AW'(4);
        state_next = ST_R_SZ;
      end
      ST_R_SZ: state_next = ST_R_W1;
      ST_R_W1: begin
        mem_we     = 1'b1;
        mem_addr   = wp - AW'(4);
        mem_wd     = 32'(sz);
        state_next = ST_R_W2;
      end
      ST_R_W2: begin
        mem_we     = 1'b1;
        mem_addr   = wp + sz - AW'(8);
        mem_wd     = 32'(sz);
        state_next = ST_M_H;
      end
      ST_DONE: begin
        if (done_ld) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_end   <= AW'(RESET_HEAP_END);
      grow_chunk <= CFG_WIDTH'(RESET_CHUNK);
      heap_limit <= CFG_WIDTH'(RESET_LIMIT);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GROW_CHUNK: grow_chunk <= cfg_data;
          CFG_HEAP_LIMIT: heap_limit <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_GR_W3) heap_end <= heap_end + sz;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid && mem_ready) cur <= req;
      end
      ST_DECODE: begin
        res     <= '0;
        copy    <= '0;
        move    <= 1'b0;
        in_grow <= 1'b0;
        asize   <= asize_calc;
        p       <= AW'(LIST_START);
        if ((cur.op == OP_MALLOC || cur.op == OP_REALLOC) && zero_size) begin
          status <= STATUS_NULL;
        end else if (cur.op == OP_REALLOC && cur.block_addr != '0 && pre_bad) begin
          status <= STATUS_OOM;
        end else begin
          status <= STATUS_OK;
        end
      end
      ST_V_H: begin
        blk  <= rd_size;
        htag <= mem_rd;
        if (hdr_bad && cur.op == OP_REALLOC && !zero_size) status <= STATUS_OOM;
      end
      ST_V_F: begin
        wp <= bp;
        if (mem_rd != htag && cur.op == OP_REALLOC && !zero_size) status <= STATUS_OOM;
      end
      ST_RA_NX: begin
        sz <= nx_sum;
        if (!(!rd_used && nx_sum >= asize)) begin
          move <= 1'b1;
          p    <= AW'(LIST_START);
        end
      end
      ST_FF_CHK: begin
        if (rd_size != '0 && !rd_used && asize <= rd_size) begin
          wp <= p;
        end else begin
          p <= p + rd_size;
        end
      end
      ST_GR_CALC: begin
        wp <= heap_end;
        sz <= gsz;
        if (grow_fail) status <= STATUS_OOM;
      end
      ST_GR_W3: in_grow <= 1'b1;
      ST_M_PF: sz <= rd_size;
      ST_M_NH: begin
        ps <= rd_size;
        pu <= rd_used;
      end
      ST_M_DEC: begin
        if (pu) begin
          sz <= sz + rd_size;
        end else begin
          wp <= wp - ps;
          sz <= sz + ps + (rd_used ? AW'(0) : rd_size);
        end
      end
      ST_P_SZ: begin
        sz    <= rd_size;
        split <= (rd_size >= asize) && ((rd_size - asize) >= AW'(MIN_BLOCK));
        res   <= wp;
      end
      ST_R_SZ: sz <= rd_size;
      default: ;
    endcase
    if (merge_end) in_grow <= 1'b0;
    if (put_end && move) begin
      copy <= blk - AW'(TAG_BYTES);
      wp   <= bp;
      move <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_ld) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ld) begin
      rsp.status      <= status;
      rsp.result_addr <= res[15:0];
      rsp.copy_bytes  <= copy[16:0];
    end
  end

endmodule

// ----- rtl/ilha_tag_mem.sv -----
`timescale 1ns / 1ps
// Tag word memory with registered read and the post-reset fill pass.
// Uses ilha_pkg for the reset heap layout constants.
module ilha_tag_mem import ilha_pkg::*; #(
  parameter int HEAP_WORDS = 16384,
  parameter int AW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wd,
  output logic [31:0]   rd,
  output logic          ready
);

  localparam int IW = $clog2(HEAP_WORDS);
  localparam logic [AW-1:0] HEAP_BYTES = AW'(HEAP_WORDS * 4);

  logic [31:0]   mem [HEAP_WORDS];
  logic [IW:0]   cnt;
  logic [31:0]   q;
  logic          q_zero;
  logic          in_range;
  logic [IW-1:0] idx;
  logic [31:0]   fill_val;

  assign in_range = addr < HEAP_BYTES;
  assign idx      = addr[IW+1:2];
  assign ready    = cnt == (IW+1)'(HEAP_WORDS);
  assign rd       = q_zero ? 32'd0 : q;

  always_comb begin
    fill_val = 32'd0;
    if (cnt == (IW+1)'(1) || cnt == (IW+1)'(2)) begin
      fill_val = 32'(PROLOGUE_TAG);
    end else if (cnt == (IW+1)'(3) || cnt == (IW+1)'(3 + RESET_CHUNK / 4 - 1)) begin
      fill_val = 32'(RESET_CHUNK);
    end else if (cnt == (IW+1)'(3 + RESET_CHUNK / 4)) begin
      fill_val = 32'(EPILOGUE_TAG);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (!ready) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[cnt[IW-1:0]] <= fill_val;
    end else if (we && in_range) begin
      mem[idx] <= wd;
    end
    if (re) begin
      q      <= mem[idx];
      q_zero <= !in_range;
    end
  end

endmodule

// ----- verif/tb_implicit_list_heap_allocator.sv -----
`timescale 1ns / 1ps
// Testbench for implicit_list_heap_allocator: directed table, then random
// malloc/free/realloc traffic checked against a tag-level allocator model.
// Depends on ilha_pkg and the DUT only.
module tb_implicit_list_heap_allocator;
  import ilha_pkg::*;

  localparam int HW = 16384;
  localparam int WATCHDOG = 400000;
  typedef longint unsigned u64;

  logic clk = 1'b0;
  logic rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall, cfg_we, cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;
  req_t req;
  rsp_t rsp;

  implicit_list_heap_allocator #(.HEAP_WORDS(HW)) DUT (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // allocator model state
  bit [31:0] tags [HW];
  u64 heap_end, grow_chunk, heap_limit;
  rsp_t pending_rsp[$];
  logic [15:0] live_blocks[$];
  int errors, checked, n_malloc, n_free, n_realloc, n_moves, n_oom, idle_ctr;
  bit quiet;

  function automatic bit [31:0] tag_rd(u64 a);
    return ((a >> 2) < HW) ? tags[a >> 2] : 32'd0;
  endfunction

  function automatic void tag_wr(u64 a, u64 v);
    if ((a >> 2) < HW) tags[a >> 2] = v[31:0];
  endfunction

  function automatic u64 blk_size(u64 a);
    return tag_rd(a) & ~32'h7;
  endfunction

  function automatic bit blk_used(u64 a);
    return tag_rd(a) & 1;
  endfunction

  function automatic void set_tags(u64 bp, u64 sz, u64 used);
    tag_wr(bp - 4, sz | used);
    tag_wr(bp + sz - 8, sz | used);
  endfunction

  function automatic u64 coalesce(u64 bp);
    u64 sz, ps;
    bit pu, nu;
    sz = blk_size(bp - 4);
    pu = blk_used(bp - 8);
    nu = blk_used(bp + sz - 4);
    if (pu && nu) return bp;
    if (pu) begin
      sz += blk_size(bp + sz - 4);
      set_tags(bp, sz, 0);
      return bp;
    end
    ps = blk_size(bp - 8);
    if (!nu) sz += blk_size(bp + sz - 4);
    sz += ps;
    set_tags(bp - ps, sz, 0);
    return bp - ps;
  endfunction

  function automatic u64 grow_heap(u64 need);
    u64 ext, words, sz, bp;
    ext = (need > grow_chunk) ? need : grow_chunk;
    words = ext >> 2;
    words += words & 1;
    sz = words * 4;
    if (heap_end + sz > heap_limit || heap_end + sz > HW * 4) return 0;
    bp = heap_end;
    set_tags(bp, sz, 0);
    tag_wr(bp + sz - 4, 1);
    heap_end += sz;
    return coalesce(bp);
  endfunction

  function automatic u64 scan_fit(u64 asize);
    u64 p, sz;
    bit [31:0] h;
    p = LIST_START;
    while (p < heap_end) begin
      h = tag_rd(p - 4);
      sz = h & ~32'h7;
      if (sz == 0) break;
      if (!h[0] && asize <= sz) return p;
      p += sz;
    end
    return 0;
  endfunction

  function automatic void place(u64 bp, u64 asize);
    u64 sz;
    sz = blk_size(bp - 4);
    if (sz >= asize && sz - asize >= MIN_BLOCK) begin
      set_tags(bp, asize, 1);
      set_tags(bp + asize, sz - asize, 0);
    end else begin
      set_tags(bp, sz, 1);
    end
  endfunction

  function automatic u64 round_block(u64 size);
    if (size <= TAG_BYTES) return MIN_BLOCK;
    return TAG_BYTES * ((size + 2 * TAG_BYTES - 1) / TAG_BYTES);
  endfunction

  function automatic bit is_live_block(u64 bp);
    bit [31:0] h;
    u64 sz;
    if (bp == 0 || bp[2:0] != 0 || bp < LIST_START + 8) return 0;
    h = tag_rd(bp - 4);
    sz = h & ~32'h7;
    if (!h[0] || sz < MIN_BLOCK || bp + sz > heap_end) return 0;
    return tag_rd(bp + sz - 8) == h;
  endfunction

  function automatic void release_block(u64 bp);
    set_tags(bp, blk_size(bp - 4), 0);
    void'(coalesce(bp));
  endfunction

  function automatic u64 alloc_bytes(u64 size, ref logic [1:0] st);
    u64 asize, bp;
    if (size == 0) begin
      st = STATUS_NULL;
      return 0;
    end
    asize = round_block(size);
    bp = scan_fit(asize);
    if (bp == 0) bp = grow_heap(asize);
    if (bp == 0) begin
      st = STATUS_OOM;
      return 0;
    end
    place(bp, asize);
    st = STATUS_OK;
    return bp;
  endfunction

  function automatic rsp_t alloc_model_step(req_t w);
    rsp_t r;
    logic [1:0] st;
    u64 bp, size, res, cp, asize, blk, nx, sum, nb;
    bp = w.block_addr;
    size = w.request_size;
    st = STATUS_OK;
    res = 0;
    cp = 0;
    case (w.op)
      OP_MALLOC: begin
        n_malloc++;
        res = alloc_bytes(size, st);
      end
      OP_FREE: begin
        n_free++;
        if (is_live_block(bp)) release_block(bp);
      end
      OP_REALLOC: begin
        n_realloc++;
        if (bp == 0) begin
          res = alloc_bytes(size, st);
        end else if (size == 0) begin
          if (is_live_block(bp)) release_block(bp);
          st = STATUS_NULL;
        end else if (!is_live_block(bp)) begin
          st = STATUS_OOM;
        end else begin
          asize = round_block(size);
          blk = blk_size(bp - 4);
          nx = bp + blk;
          sum = blk_size(nx - 4) + blk;
          if (asize <= blk) begin
            place(bp, asize);
            res = bp;
          end else if (!blk_used(nx - 4) && sum >= asize) begin
            tag_wr(bp - 4, sum);
            place(bp, asize);
            res = bp;
          end else begin
            nb = scan_fit(asize);
            if (nb == 0) nb = grow_heap(asize);
            if (nb == 0) begin
              st = STATUS_OOM;
            end else begin
              place(nb, asize);
              cp = blk - TAG_BYTES;
              release_block(bp);
              res = nb;
              n_moves++;
            end
          end
        end
      end
      default: ;
    endcase
    if (st == STATUS_OOM) n_oom++;
    r.status = st;
    r.result_addr = res[15:0];
    r.copy_bytes = cp[16:0];
    return r;
  endfunction

  function automatic void drop_live(logic [15:0] a);
    foreach (live_blocks[i]) begin
      if (live_blocks[i] == a) begin
        live_blocks.delete(i);
        return;
      end
    end
  endfunction

  function automatic void track_live(req_t w, rsp_t r);
    if (w.op == OP_FREE) drop_live(w.block_addr);
    if (w.op == OP_REALLOC && w.block_addr != 0 && r.status != STATUS_OOM &&
        r.result_addr != w.block_addr) drop_live(w.block_addr);
    if ((w.op == OP_MALLOC || w.op == OP_REALLOC) && r.result_addr != 0 &&
        r.result_addr != w.block_addr) live_blocks.push_back(r.result_addr);
  endfunction

  task automatic send_word(req_t w, bit known, rsp_t want);
    rsp_t r;
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    r = alloc_model_step(w);
    track_live(w, r);
    pending_rsp.push_back(known ? want : r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain_and_hold();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_WIDTH-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GROW_CHUNK) grow_chunk = val & 17'h1FFFF;
    else heap_limit = val & 17'h1FFFF;
  endtask

  function automatic req_t random_word();
    req_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.op = OP_MALLOC;
    w.block_addr = 0;
    case ($urandom_range(0, 19))
      0: w.request_size = 0;
      1: w.request_size = $urandom_range(0, 131071);
      2, 3: w.request_size = $urandom_range(257, 4096);
      default: w.request_size = $urandom_range(1, 256);
    endcase
    if (live_blocks.size() > 50) pick = (pick < 40) ? 50 : pick;
    if (pick < 40) begin
      w.op = OP_MALLOC;
    end else if (pick < 70) begin
      w.op = OP_FREE;
    end else if (pick < 94) begin
      w.op = OP_REALLOC;
    end else begin
      w.op = 2'($urandom_range(0, 3));
      w.block_addr = 16'($urandom_range(0, 65535));
      return w;
    end
    if (w.op != OP_MALLOC && live_blocks.size() != 0 && $urandom_range(0, 9) != 0)
      w.block_addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    else if (w.op != OP_MALLOC && $urandom_range(0, 1) == 0)
      w.block_addr = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  typedef struct {
    req_t w;
    bit known;
    rsp_t want;
  } dir_row_t;

  function automatic req_t mk(logic [1:0] op, logic [15:0] a, logic [16:0] s);
    req_t w;
    w.op = op;
    w.block_addr = a;
    w.request_size = s;
    return w;
  endfunction

  function automatic rsp_t rs(logic [1:0] st, logic [15:0] a);
    rsp_t r;
    r.status = st;
    r.result_addr = a;
    r.copy_bytes = 0;
    return r;
  endfunction

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      checked++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %p", $time, rsp);
      end else begin
        if (rsp.status != pending_rsp[0].status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time,
                   pending_rsp[0].status, rsp.status);
        end
        if (rsp.result_addr != pending_rsp[0].result_addr) begin
          errors++;
          $display("%0t: result_addr expected %0d actual %0d", $time,
                   pending_rsp[0].result_addr, rsp.result_addr);
        end
        if (rsp.copy_bytes != pending_rsp[0].copy_bytes) begin
          errors++;
          $display("%0t: copy_bytes expected %0d actual %0d", $time,
                   pending_rsp[0].copy_bytes, rsp.copy_bytes);
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_ctr <= 0;
    else idle_ctr <= idle_ctr + 1;
    if (idle_ctr >= WATCHDOG) begin
      $display("tb_implicit_list_heap_allocator failed");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    rsp_t none;
    int unsigned g, l;
    none = rs(STATUS_OK, 0);
    errors = 0; checked = 0; idle_ctr = 0; quiet = 0;
    n_malloc = 0; n_free = 0; n_realloc = 0; n_moves = 0; n_oom = 0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_GROW_CHUNK;
    cfg_data <= '0;
    tags = '{default: 0};
    tag_wr(4, PROLOGUE_TAG);
    tag_wr(8, PROLOGUE_TAG);
    set_tags(16, RESET_CHUNK, 0);
    tag_wr(16 + RESET_CHUNK - 4, EPILOGUE_TAG);
    heap_end = RESET_HEAP_END;
    grow_chunk = RESET_CHUNK;
    heap_limit = RESET_LIMIT;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{mk(OP_MALLOC, 0, 0), 1, rs(STATUS_NULL, 0)});
    rows.push_back('{mk(OP_MALLOC, 0, 1), 1, rs(STATUS_OK, 16)});
    rows.push_back('{mk(OP_MALLOC, 0, 100), 0, none});
    rows.push_back('{mk(OP_REALLOC, 16, 200), 0, none});
    rows.push_back('{mk(OP_FREE, 0, 0), 1, none});
    rows.push_back('{mk(2'd3, 16'hFFFF, 17'h1FFFF), 1, none});
    rows.push_back('{mk(OP_REALLOC, 16'hFFFF, 1), 1, rs(STATUS_OOM, 0)});
    rows.push_back('{mk(OP_REALLOC, 12, 0), 1, rs(STATUS_NULL, 0)});
    rows.push_back('{mk(OP_MALLOC, 0, 65536), 1, rs(STATUS_OOM, 0)});
    rows.push_back('{mk(OP_MALLOC, 0, 17'h1FFFF), 1, rs(STATUS_OOM, 0)});
    rows.push_back('{mk(OP_REALLOC, 0, 40), 0, none});
    rows.push_back('{mk(OP_REALLOC, 32, 8), 0, none});
    rows.push_back('{mk(OP_REALLOC, 32, 60), 0, none});
    rows.push_back('{mk(OP_FREE, 32, 0), 0, none});
    rows.push_back('{mk(OP_FREE, 32, 0), 0, none});
    rows.push_back('{mk(OP_MALLOC, 0, 5000), 0, none});
    rows.push_back('{mk(OP_MALLOC, 0, 8), 0, none});
    rows.push_back('{mk(OP_REALLOC, 16'd8, 5), 0, none});
    rows.push_back('{mk(OP_FREE, 16'hFFF8, 0), 0, none});
    rows.push_back('{mk(OP_MALLOC, 0, 60000), 0, none});
    foreach (rows[i]) send_word(rows[i].w, rows[i].known, rows[i].want);
    drain_and_hold();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_GROW_CHUNK, 16); write_cfg(CFG_HEAP_LIMIT, 65536); end
        1: begin write_cfg(CFG_GROW_CHUNK, 65536); write_cfg(CFG_HEAP_LIMIT, 32); end
        2: begin write_cfg(CFG_GROW_CHUNK, 17'h1FFFF); write_cfg(CFG_HEAP_LIMIT, 17'h1FFFF); end
        default: begin
          g = $urandom_range(16, 65536);
          l = $urandom_range(32, 65536);
          write_cfg(CFG_GROW_CHUNK, g);
          write_cfg(CFG_HEAP_LIMIT, l);
        end
      endcase
      for (int k = 0; k < 250; k++) begin
        if (ph == 3 && k == 150) quiet = 1;
        if (k == 100) begin
          req_valid <= 1'b0;
          while (pending_rsp.size() != 0) @(posedge clk);
        end
        send_word(random_word(), 0, none);
      end
      drain_and_hold();
    end

    $display("covered %0d malloc, %0d free, %0d realloc requests; %0d moves, %0d out of memory",
             n_malloc, n_free, n_realloc, n_moves, n_oom);
    $display("%0d response words checked over 5 register settings", checked);
    if (errors == 0) begin
      $display("tb_implicit_list_heap_allocator passed");
    end else begin
      $display("tb_implicit_list_heap_allocator failed");
    end
    $finish;
  end

endmodule
